// File: src/wpm_pkg.sv
package wpm_pkg;

   localparam int MAX_PATTERN = 63;
   localparam int ROW_BITS    = MAX_PATTERN + 1;

   localparam logic [7:0] STAR_BYTE  = 8'h2A;
   localparam logic [7:0] QMARK_BYTE = 8'h3F;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } command_type;

   // Broadcast to every position of the chain for the accepted word.
   typedef struct packed {
      logic       clear;
      logic       append;
      logic       text;
      logic       restart;
      logic [7:0] data;
   } cell_ctl_type;

   // What one position hands to its right-hand neighbor.
   typedef struct packed {
      logic valid;
      logic init;
      logic match;
      logic next;
   } link_type;

endpackage

// File: src/wpm_cell.sv
module wpm_cell
   import wpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  link_type     prev,
   output link_type     link
);

   logic       valid_ff, valid_in;
   logic [7:0] pat_ff, pat_in;
   logic       init_ff, init_in;
   logic       match_ff, match_in;
   logic       load;
   logic       next;

   // The first empty position takes the appended byte.
   assign load = ctl.append && prev.valid && !valid_ff;

   always_comb begin
      valid_in = valid_ff;
      pat_in   = pat_ff;
      init_in  = init_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
         init_in  = 1'b0;
      end else if (load) begin
         valid_in = 1'b1;
         pat_in   = ctl.data;
         init_in  = prev.init && (ctl.data == STAR_BYTE);
      end
   end

   // A star ORs in the new value on its left, so runs of stars ripple along the chain.
   always_comb begin
      if (!valid_ff) begin
         next = 1'b0;
      end else if (pat_ff == STAR_BYTE) begin
         next = match_ff || prev.next;
      end else if ((pat_ff == QMARK_BYTE) || (pat_ff == ctl.data)) begin
         next = prev.match;
      end else begin
         next = 1'b0;
      end
   end

   // The match bit only moves when a word is taken.
   assign match_in = ctl.text ? next : (ctl.restart ? init_in : match_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         init_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         init_ff  <= init_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

   assign link.valid = valid_ff;
   assign link.init  = init_ff;
   assign link.match = match_ff;
   assign link.next  = next;

endmodule

// File: src/wildcard_pattern_matcher.sv
// Whole-string wildcard matcher: '?' matches any one byte, '*' any run of bytes.
// Request channel (req_valid/req_ready) carries one word per command: clear the
// pattern, append a pattern byte, stream a text byte, or end the text. Only an
// end-of-text word yields a response word on rsp_valid/rsp_ready, holding
// rsp_matched and rsp_overflow.
// Commands are taken at one word per cycle while no response waits on a low
// rsp_ready; the rate is set by the row of pattern positions, which all update
// together from each text byte. A response appears the cycle after its end-of-text word.
// The response sits in one output register; while it waits and rsp_ready is
// low, req_ready drops and no further word is taken.
// Appending beyond the capacity sets a sticky overflow flag that forces
// rsp_matched low until the next clear. A pattern command issued mid-text
// abandons that text.
// Reset leaves an empty pattern, cleared overflow, and no pending response;
// no clearing pass is needed.
module wildcard_pattern_matcher
   import wpm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_matched,
   output logic        rsp_overflow
);

   cell_ctl_type           ctl;
   link_type               links [0:MAX_PATTERN];
   logic                   fire;
   logic                   is_end;
   logic                   match0_ff, match0_in;
   logic                   overflow_ff, overflow_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_matched_ff, rsp_matched_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;
   logic [MAX_PATTERN:0]   valid_row;
   logic [MAX_PATTERN:0]   last_row;
   logic                   hit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   assign ctl.clear   = fire && (req_command == CMD_CLEAR);
   assign ctl.append  = fire && (req_command == CMD_APPEND);
   assign ctl.text    = fire && (req_command == CMD_TEXT);
   assign ctl.restart = fire && (req_command != CMD_TEXT);
   assign ctl.data    = req_byte_value;
   assign is_end      = fire && (req_command == CMD_END);

   // Position zero is the empty prefix: always present and all-star.
   assign links[0].valid = 1'b1;
   assign links[0].init  = 1'b1;
   assign links[0].match = match0_ff;
   assign links[0].next  = 1'b0;

   assign match0_in = ctl.text ? 1'b0 : (ctl.restart ? 1'b1 : match0_ff);

   for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cells
      wpm_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .prev  (links[j-1]),
         .link  (links[j])
      );
   end

   // The last filled position carries the whole-pattern match bit.
   always_comb begin
      for (int j = 0; j <= MAX_PATTERN; j++) begin
         valid_row[j] = links[j].valid;
      end
      for (int j = 0; j < MAX_PATTERN; j++) begin
         last_row[j] = links[j].valid && !links[j+1].valid;
      end
      last_row[MAX_PATTERN] = links[MAX_PATTERN].valid;
      hit = 1'b0;
      for (int j = 0; j <= MAX_PATTERN; j++) begin
         hit = hit | (last_row[j] && links[j].match);
      end
   end

   always_comb begin
      overflow_in = overflow_ff;
      if (ctl.clear) begin
         overflow_in = 1'b0;
      end else if (ctl.append && links[MAX_PATTERN].valid) begin
         overflow_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_matched_in  = rsp_matched_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (is_end) begin
         rsp_valid_in    = 1'b1;
         rsp_matched_in  = !overflow_ff && hit;
         rsp_overflow_in = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match0_ff    <= 1'b1;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         match0_ff    <= match0_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff  <= rsp_matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_valid_contiguous: assert property (@(posedge clock) disable iff (reset)
      (valid_row[MAX_PATTERN:1] & ~valid_row[MAX_PATTERN-1:0]) == '0)
      else $error("pattern positions are not filled from the left");

   a_single_tail: assert property (@(posedge clock) disable iff (reset)
      $onehot(last_row))
      else $error("pattern tail is not unique");

   a_overflow_no_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_overflow_ff) |-> !rsp_matched_ff)
      else $error("match reported on an overflowed pattern");

   a_end_gives_word: assert property (@(posedge clock) disable iff (reset)
      is_end |=> rsp_valid_ff)
      else $error("end of text produced no response word");
`endif

endmodule
